// File: sv/subcode_q_crc_check_top_macros.svh
// Assertion macros for the subchannel Q CRC checker.
// Used by subcode_q_crc_check_top; expects clk_i and rst_ni in scope.
`ifndef SUBCODE_Q_CRC_CHECK_TOP_MACROS_SVH
`define SUBCODE_Q_CRC_CHECK_TOP_MACROS_SVH

// same-cycle implication
`define SQC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SQC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/subq_pkg.sv
// Shared constants and types for the subchannel Q CRC checker.
// No dependencies.
`default_nettype none

package subq_pkg;

  localparam int unsigned FrameLen  = 12;
  localparam int unsigned CrcSpan   = 10;
  localparam int unsigned WipeFirst = 3;
  localparam int unsigned WipeCount = 7;
  localparam int unsigned PosW      = 4;

  localparam logic [15:0]     CrcPoly = 16'h1021;
  localparam logic [PosW-1:0] LastPos = PosW'(FrameLen - 1);

  typedef struct packed {
    logic                         load;
    logic                         ok;
    logic [FrameLen-1:0][7:0]     bytes;
  } frame_t;

endpackage

`default_nettype wire

// File: sv/subq_crc_step.sv
// One byte of CRC-16 (poly 0x1021, MSB first).
// Depends on subq_pkg.
`default_nettype none

module subq_crc_step
  import subq_pkg::*;
(
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  byte_i,
  output logic      [15:0] crc_o
);

  logic [15:0] c;

  always_comb begin
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

`default_nettype wire

// File: sv/subq_collect.sv
// Input side: byte counter, running CRC, frame buffer and pass/fail check.
// Depends on subq_pkg and subq_crc_step.
`default_nettype none

module subq_collect
  import subq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] q_byte_i,
  input  wire logic       frame_start_i,
  input  wire logic       emit_busy_i,
  output frame_t          frame_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_eff;
  logic [15:0]     crc_q, crc_d, crc_base, crc_nxt;
  logic [7:0]      buf_q [FrameLen-1];
  logic            acc, complete, ok;

  subq_crc_step u_crc (
    .crc_i  (crc_base),
    .byte_i (q_byte_i),
    .crc_o  (crc_nxt)
  );

  assign in_ready_o = !((pos_q == LastPos) && emit_busy_i);
  assign acc        = in_valid_i && in_ready_o;
  assign pos_eff    = frame_start_i ? '0 : pos_q;
  assign crc_base   = frame_start_i ? '0 : crc_q;
  assign complete   = acc && (pos_eff == LastPos);
  assign ok         = (~crc_q == {buf_q[CrcSpan], q_byte_i});

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (acc) begin
      if (complete) begin
        pos_d = '0;
        crc_d = '0;
      end else begin
        pos_d = pos_eff + 1'b1;
        crc_d = (pos_eff < PosW'(CrcSpan)) ? crc_nxt : crc_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !complete) begin
      buf_q[pos_eff] <= q_byte_i;
    end
  end

  always_comb begin
    frame_o.load = complete;
    frame_o.ok   = ok;
    for (int k = 0; k < FrameLen - 1; k++) begin
      if (!ok && k >= WipeFirst && k < WipeFirst + WipeCount) begin
        frame_o.bytes[k] = '0;
      end else begin
        frame_o.bytes[k] = buf_q[k];
      end
    end
    frame_o.bytes[FrameLen-1] = q_byte_i;
  end

endmodule

`default_nettype wire

// File: sv/subq_emit.sv
// Output side: holds one checked frame; sends one item a cycle while out_ready_i is high.
// Depends on subq_pkg.
`default_nettype none

module subq_emit
  import subq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire frame_t     frame_i,
  output logic            busy_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] out_byte_o,
  output logic            crc_ok_o,
  output logic            frame_last_o
);

  logic                     busy_q, busy_d;
  logic [PosW-1:0]          idx_q, idx_d;
  logic                     ok_q;
  logic [FrameLen-1:0][7:0] buf_q;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (frame_i.load) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q && out_ready_i) begin
      if (idx_q == LastPos) begin
        busy_d = 1'b0;
        idx_d  = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.load) begin
      buf_q <= frame_i.bytes;
      ok_q  <= frame_i.ok;
    end
  end

  assign busy_o       = busy_q;
  assign out_valid_o  = busy_q;
  assign out_byte_o   = buf_q[idx_q];
  assign crc_ok_o     = ok_q;
  assign frame_last_o = (idx_q == LastPos);

endmodule

`default_nettype wire

// File: sv/subcode_q_crc_check_top.sv
// Latency: first item of a frame is valid the cycle after its twelfth byte is taken.
// Throughput: one byte in and one item out per cycle while neither side stalls;
// bytes 0-10 of the next frame enter while the current frame drains, and its
// twelfth byte waits until the output buffer has sent its last item.
// Reset (async, active low) clears the byte count, CRC and output valid.
`default_nettype none

`include "subcode_q_crc_check_top_macros.svh"

module subcode_q_crc_check_top
  import subq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] q_byte_i,
  input  wire logic       frame_start_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [7:0] out_byte_o,
  output logic            crc_ok_o,
  output logic            frame_last_o
);

  frame_t frm;
  logic   emit_busy;

  subq_collect u_collect (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .q_byte_i      (q_byte_i),
    .frame_start_i (frame_start_i),
    .emit_busy_i   (emit_busy),
    .frame_o       (frm)
  );

  subq_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_i      (frm),
    .busy_o       (emit_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .crc_ok_o     (crc_ok_o),
    .frame_last_o (frame_last_o)
  );

  `SQC_ASSERT(a_no_overwrite, frm.load, !out_valid_o, "frame loaded over one still sending")
  `SQC_ASSERT_NXT(a_load_starts, frm.load, out_valid_o && !frame_last_o,
                  "loaded frame does not start at its first item")
  `SQC_ASSERT(a_stall_cause, !in_ready_o, out_valid_o, "input stalled with output idle")

endmodule

`default_nettype wire
